// ===== hw/rtl/manchester_frame_receiver_unit_assert.svh =====
// Assertion helpers for the Manchester frame receiver.
`ifndef MANCHESTER_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define MANCHESTER_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mfr_pkg.sv =====
`default_nettype none

package mfr_pkg;

  localparam int unsigned TicksW   = 32;
  localparam int unsigned NomW     = 20;
  localparam int unsigned HalfW    = 24;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CFG_RX_ENABLE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_NOMINAL   = 1'd1;

  localparam logic [NomW-1:0]  NOMINAL_RESET = 20'd1000;
  localparam logic [NomW-1:0]  MIN_HALF      = 20'd8;
  localparam logic [15:0]      SYNC_WORD     = 16'hFF2D;
  localparam logic [15:0]      CRC_POLY      = 16'h1021;
  localparam logic [15:0]      CRC_INIT      = 16'hFFFF;

  typedef enum logic [1:0] {
    RK_BYTE    = 2'd0,
    RK_OK      = 2'd1,
    RK_CRC_ERR = 2'd2
  } result_kind_e;

  // Tracker to framer: one decoded bit and/or a receiver clear.
  typedef struct packed {
    logic bit_valid;
    logic bit_val;
    logic clear;
  } trk_t;

  typedef struct packed {
    logic         valid;
    result_kind_e kind;
    logic [7:0]   data;
    logic [7:0]   offset;
    logic [7:0]   length;
  } res_t;

  // CRC16-CCITT, one byte, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mfr_edge_tracker.sv =====
`default_nettype none

// Clock recovery: lock, cell-boundary versus mid-cell decision, half-cell tracking.
module mfr_edge_tracker (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           step_i,
  input  wire                           level_i,
  input  wire [mfr_pkg::TicksW-1:0]     dt_i,
  input  wire                           rx_enable_i,
  input  wire [mfr_pkg::NomW-1:0]       nominal_i,
  input  wire                           cfg_clear_i,
  input  wire                           frame_done_i,
  output mfr_pkg::trk_t                 trk_o
);

  logic                        locked_q, locked_d;
  logic                        exp_mid_q, exp_mid_d;
  logic [mfr_pkg::HalfW-1:0]   half_q, half_d;

  logic [mfr_pkg::NomW-1:0]    nom_eff;
  logic [mfr_pkg::HalfW-1:0]   h;
  logic [33:0]                 dt_w, h4, h3, dt2, meas, sum, est, lo, hi;
  logic                        gap, short_gap, do_track, start;

  always_comb begin
    nom_eff   = (nominal_i < mfr_pkg::MIN_HALF) ? mfr_pkg::MIN_HALF : nominal_i;
    h         = (half_q != '0) ? half_q : {4'b0, nom_eff};
    dt_w      = {2'b0, dt_i};
    dt2       = {1'b0, dt_i, 1'b0};
    h4        = {8'b0, h, 2'b0};
    h3        = {10'b0, h} + {9'b0, h, 1'b0};
    gap       = dt_w > h4;
    short_gap = dt2 < h3;

    locked_d  = locked_q;
    exp_mid_d = exp_mid_q;
    half_d    = half_q;
    trk_o     = '0;
    trk_o.bit_val = ~level_i;
    do_track  = 1'b0;
    start     = 1'b0;
    meas      = dt_w;

    if (rx_enable_i) begin
      if (!locked_q) begin
        start = level_i;
      end else if (gap) begin
        trk_o.clear = 1'b1;
        start       = level_i;
        locked_d    = 1'b0;
        exp_mid_d   = 1'b0;
        half_d      = '0;
      end else if (exp_mid_q) begin
        do_track        = 1'b1;
        exp_mid_d       = 1'b0;
        trk_o.bit_valid = 1'b1;
      end else if (short_gap) begin
        do_track  = 1'b1;
        exp_mid_d = 1'b1;
      end else begin
        // Cell-boundary spacing covers two half cells.
        do_track        = 1'b1;
        meas            = {1'b0, dt_w[33:1]};
        exp_mid_d       = 1'b0;
        trk_o.bit_valid = 1'b1;
      end
    end

    // Estimate follows (3*est + measured)/4, clamped to [nom/8, nom*8].
    sum = {10'b0, half_q} + {9'b0, half_q, 1'b0} + meas;
    est = {2'b0, sum[33:2]};
    lo  = {17'b0, nom_eff[mfr_pkg::NomW-1:3]};
    hi  = {11'b0, nom_eff, 3'b0};
    if (est < lo) est = lo;
    if (est > hi) est = hi;
    if (do_track && meas != '0) begin
      half_d = est[mfr_pkg::HalfW-1:0];
    end

    if (start) begin
      trk_o.clear = 1'b1;
      locked_d    = 1'b1;
      exp_mid_d   = 1'b1;
      half_d      = {4'b0, nom_eff};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q  <= 1'b0;
      exp_mid_q <= 1'b0;
      half_q    <= '0;
    end else if (cfg_clear_i || (step_i && frame_done_i)) begin
      locked_q  <= 1'b0;
      exp_mid_q <= 1'b0;
      half_q    <= '0;
    end else if (step_i) begin
      locked_q  <= locked_d;
      exp_mid_q <= exp_mid_d;
      half_q    <= half_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mfr_framer.sv =====
`default_nettype none

// Sync hunt, byte assembly, length/payload/CRC framing.
module mfr_framer (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             step_i,
  input  mfr_pkg::trk_t   trk_i,
  input  wire             cfg_clear_i,
  output mfr_pkg::res_t   res_o
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [15:0] hunt_q, hunt_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  acc_q, acc_d, acc_n;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  len_q, len_d;
  logic [8:0]  bytes_q, bytes_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic        clear_all;

  always_comb begin
    hunt_d   = hunt_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    bytes_d  = bytes_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    acc_n    = {acc_q[6:0], trk_i.bit_val};
    clear_all = trk_i.clear;

    res_o        = '0;
    res_o.kind   = mfr_pkg::RK_BYTE;
    res_o.length = len_q;

    if (!trk_i.clear && trk_i.bit_valid) begin
      unique case (phase_q) inside
        PH_LENGTH, PH_PAYLOAD: begin
          if (cnt_q != 3'd7) begin
            cnt_d = cnt_q + 3'd1;
            acc_d = acc_n;
          end else begin
            cnt_d = '0;
            acc_d = '0;
            if (phase_q == PH_LENGTH) begin
              len_d   = acc_n;
              crc_d   = mfr_pkg::crc_feed(crc_q, acc_n);
              bytes_d = '0;
              phase_d = PH_PAYLOAD;
            end else if (bytes_q < {1'b0, len_q}) begin
              res_o.valid  = 1'b1;
              res_o.data   = acc_n;
              res_o.offset = bytes_q[7:0];
              crc_d        = mfr_pkg::crc_feed(crc_q, acc_n);
              bytes_d      = bytes_q + 9'd1;
            end else if (bytes_q == {1'b0, len_q}) begin
              crc_hi_d = acc_n;
              bytes_d  = bytes_q + 9'd1;
            end else begin
              res_o.valid = 1'b1;
              res_o.kind  = ({crc_hi_q, acc_n} == crc_q) ? mfr_pkg::RK_OK
                                                         : mfr_pkg::RK_CRC_ERR;
              clear_all   = 1'b1;
            end
          end
        end
        default: begin
          // Hunting; the unused phase code hunts too.
          hunt_d = {hunt_q[14:0], trk_i.bit_val};
          if (hunt_d == mfr_pkg::SYNC_WORD) begin
            phase_d = PH_LENGTH;
            acc_d   = '0;
            cnt_d   = '0;
            bytes_d = '0;
            crc_d   = mfr_pkg::CRC_INIT;
          end
        end
      endcase
    end

    if (clear_all) begin
      hunt_d   = '0;
      phase_d  = PH_HUNT;
      acc_d    = '0;
      cnt_d    = '0;
      len_d    = '0;
      bytes_d  = '0;
      crc_d    = mfr_pkg::CRC_INIT;
      crc_hi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q   <= '0;
      phase_q  <= PH_HUNT;
      acc_q    <= '0;
      cnt_q    <= '0;
      len_q    <= '0;
      bytes_q  <= '0;
      crc_q    <= mfr_pkg::CRC_INIT;
      crc_hi_q <= '0;
    end else if (cfg_clear_i) begin
      hunt_q   <= '0;
      phase_q  <= PH_HUNT;
      acc_q    <= '0;
      cnt_q    <= '0;
      len_q    <= '0;
      bytes_q  <= '0;
      crc_q    <= mfr_pkg::CRC_INIT;
      crc_hi_q <= '0;
    end else if (step_i) begin
      hunt_q   <= hunt_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      bytes_q  <= bytes_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/manchester_frame_receiver_unit.sv =====
// Manchester frame receiver: line edges in, payload bytes and frame status out.
// An edge waits in the input register; its result is offered from the result register.
// Throughput: one edge per clock while no result stalls; single-pass edge and framing logic.
// Reset (rst_ni, async, active low): receive disabled, half cell 1000 ticks, receiver unlocked
// and hunting for sync, CRC preset to all ones, input and result stages empty.
`default_nettype none

module manchester_frame_receiver_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Edge stream.
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire  [39:0]                       s_axis_tdata_i,  // line_level, elapsed_ticks[31:0], 0
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  output logic [23:0]                       m_axis_tdata_o,  // payload_byte, byte_offset,
                                                             // frame_length
  output logic [1:0]                        m_axis_tuser_o,  // result_kind
  // Configuration writes.
  input  wire                               cfg_we_i,
  input  wire  [mfr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire  [mfr_pkg::NomW-1:0]          cfg_wdata_i
);

  // Configuration registers.
  logic                        rx_enable_q;
  logic [mfr_pkg::NomW-1:0]    nominal_q;
  logic                        cfg_clear;

  // Input register.
  logic                        in_valid_q;
  logic                        in_level_q;
  logic [mfr_pkg::TicksW-1:0]  in_dt_q;

  // Result register.
  logic                        out_valid_q;
  mfr_pkg::res_t               out_q;

  logic                        advance;
  logic                        in_take;
  mfr_pkg::trk_t               trk;
  mfr_pkg::res_t               res;
  logic                        frame_done;

  // Arming receive (writing enable as 1) wipes the receiver state.
  assign cfg_clear = cfg_we_i && (cfg_index_i == mfr_pkg::CFG_RX_ENABLE) && cfg_wdata_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_enable_q <= 1'b0;
      nominal_q   <= mfr_pkg::NOMINAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mfr_pkg::CFG_RX_ENABLE: rx_enable_q <= cfg_wdata_i[0];
        mfr_pkg::CFG_NOMINAL:   nominal_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Process the held edge whenever the result register is free or being drained.
  // The result register parts the two sides, so a stalled consumer holds only
  // this stage and the input keeps flowing until the held edge itself must wait.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload of the input stage; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_level_q <= s_axis_tdata_i[0];
      in_dt_q    <= s_axis_tdata_i[mfr_pkg::TicksW:1];
    end
  end

  // A frame end returns the tracker to unlocked.
  assign frame_done = res.valid && (res.kind != mfr_pkg::RK_BYTE);

  mfr_edge_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .level_i      (in_level_q),
    .dt_i         (in_dt_q),
    .rx_enable_i  (rx_enable_q),
    .nominal_i    (nominal_q),
    .cfg_clear_i  (cfg_clear),
    .frame_done_i (frame_done),
    .trk_o        (trk)
  );

  mfr_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .trk_i       (trk),
    .cfg_clear_i (cfg_clear),
    .res_o       (res)
  );

  // Result register: load on a produced result, drop once the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.length, out_q.offset, out_q.data};
  assign m_axis_tuser_o  = out_q.kind;

endmodule

`default_nettype wire

// ===== hw/rtl/mfr_checker.sv =====
`default_nettype none
`include "manchester_frame_receiver_unit_assert.svh"

module mfr_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        m_axis_tvalid_i,
  input  wire        m_axis_tready_i,
  input  wire [23:0] m_axis_tdata_i,
  input  wire [1:0]  m_axis_tuser_i
);

  `MFR_ASSERT_NOW(a_kind_legal, clk_i, rst_ni, m_axis_tvalid_i, m_axis_tuser_i != 2'd3, "bad result kind")
  `MFR_ASSERT_NOW(a_status_no_data, clk_i, rst_ni, m_axis_tvalid_i && (m_axis_tuser_i != 2'd0), m_axis_tdata_i[15:0] == 16'd0, "status result carries data")
  `MFR_ASSERT_NOW(a_offset_in_frame, clk_i, rst_ni, m_axis_tvalid_i && (m_axis_tuser_i == 2'd0), m_axis_tdata_i[15:8] < m_axis_tdata_i[23:16], "byte offset past frame length")
  `MFR_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i), "stalled result changed")

endmodule

bind manchester_frame_receiver_unit mfr_checker u_mfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
